// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ITOAR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// The condition must never be true at a clock edge outside reset.
`define ITOAR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/core/itoar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII package
// Transaction types, mode codes and the digit to character mapping.
// ----------------------------------------------------------------------------
package itoar_pkg;

  localparam int unsigned DecBits   = 32;
  localparam int unsigned DecDigits = 10;
  localparam int unsigned HexDigits = 16;
  localparam int unsigned BcdWidth  = 4 * DecDigits;
  localparam int unsigned DigWidth  = 4 * HexDigits;
  localparam int unsigned CntWidth  = $clog2(HexDigits + 1);

  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_HEXL = 2'd2;
  localparam logic [1:0] OP_HEXU = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_LOWA  = 8'd97;
  localparam logic [7:0] CHAR_UPA   = 8'd65;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic        halted;
  } cmd_t;

  typedef struct packed {
    logic [7:0] character;
    logic [3:0] position;
    logic       last;
  } result_t;

  // Load request from the control into the character emitter.
  typedef struct packed {
    logic                load;
    logic [DigWidth-1:0] digits;
    logic [CntWidth-1:0] count;
    logic                neg;
    logic                upper;
  } emit_cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CHAR_ZERO + {4'd0, nib};
    end else if (upper) begin
      ch = CHAR_UPA + {4'd0, nib - 4'd10};
    end else begin
      ch = CHAR_LOWA + {4'd0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

// File: rtl/core/integer_to_ascii_radix_core.sv
`timescale 1ns / 1ps
// A hex transaction is loaded into the emitter when accepted; the emitter skips its leading
// zero digits before the first character; decimal adds the BCD conversion and hand-off.
// Only one transaction is handled at a time: busy stays high from acceptance until the last
// character is sent (a halted transaction leaves the block idle); the pace is set by the
// one-bit-per-cycle BCD shift register and the one-digit-per-cycle emitter.
// Reset (rst_ni low, asynchronous) returns to idle; results cannot be stalled.
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter
// Prints a 32-bit decimal or 64-bit hex value as ASCII, one character a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_ascii_radix_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  itoar_pkg::cmd_t    cmd_i,
  output logic               strobe_o,
  output itoar_pkg::result_t result_o
);

  // Controller states. In ST_CONV the BCD converter is shifting the
  // magnitude; in ST_EMIT the emitter is sending characters.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       neg_q, neg_d;

  logic                                accept;
  logic                                is_dec, is_neg;
  logic [itoar_pkg::DecBits-1:0]       low, mag;
  logic                                dab_load, dab_done;
  logic [itoar_pkg::BcdWidth-1:0]      bcd;
  itoar_pkg::emit_cmd_t                emit_cmd;
  logic                                emit_done;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Decimal modes use only the low word; signed mode prints the two's
  // complement magnitude, which also covers the most negative value.
  assign is_dec = (cmd_i.op == itoar_pkg::OP_SDEC) || (cmd_i.op == itoar_pkg::OP_UDEC);
  assign low    = cmd_i.value[itoar_pkg::DecBits-1:0];
  assign is_neg = (cmd_i.op == itoar_pkg::OP_SDEC) && low[itoar_pkg::DecBits-1];
  assign mag    = is_neg ? (~low + itoar_pkg::DecBits'(1)) : low;

  assign dab_load = accept && !cmd_i.halted && is_dec;

  // The emitter is loaded directly for hex, or with the finished BCD word
  // (ten digits placed at the top of the digit register) for decimal.
  always_comb begin
    emit_cmd.load   = dab_done || (accept && !cmd_i.halted && !is_dec);
    emit_cmd.digits = cmd_i.value;
    emit_cmd.count  = itoar_pkg::CntWidth'(itoar_pkg::HexDigits);
    emit_cmd.neg    = 1'b0;
    emit_cmd.upper  = (cmd_i.op == itoar_pkg::OP_HEXU);
    if (dab_done) begin
      emit_cmd.digits = {bcd, {(itoar_pkg::DigWidth - itoar_pkg::BcdWidth){1'b0}}};
      emit_cmd.count  = itoar_pkg::CntWidth'(itoar_pkg::DecDigits);
      emit_cmd.neg    = neg_q;
      emit_cmd.upper  = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    unique case (state_q)
      ST_IDLE: begin
        // A halted transaction is accepted and produces no characters.
        if (accept && !cmd_i.halted) begin
          if (is_dec) begin
            state_d = ST_CONV;
            neg_d   = is_neg;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
    end
  end

  itoar_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (dab_load),
    .mag_i  (mag),
    .done_o (dab_done),
    .bcd_o  (bcd)
  );

  itoar_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (emit_cmd),
    .strobe_o (strobe_o),
    .result_o (result_o),
    .done_o   (emit_done)
  );

  // Characters only appear while the emitter owns the transaction.
  `ITOAR_ASSERT(a_strobe_in_emit, strobe_o |-> (state_q == ST_EMIT))
  // The final character of a run frees the block in the next cycle.
  `ITOAR_ASSERT(a_last_frees, (strobe_o && result_o.last) |=> !busy)
  // A halted transaction leaves the block idle.
  `ITOAR_ASSERT(a_halt_idle, (accept && cmd_i.halted) |=> !busy)
  // The BCD result only completes during the conversion phase.
  `ITOAR_NEVER(a_dab_done_phase, dab_done && (state_q != ST_CONV))

endmodule

// File: rtl/core/itoar_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shifts a 32-bit magnitude in one bit per cycle with add-3 correction.
// ----------------------------------------------------------------------------
module itoar_dabble (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic [itoar_pkg::DecBits-1:0]      mag_i,
  output logic                               done_o,
  output logic [itoar_pkg::BcdWidth-1:0]     bcd_o
);

  localparam int unsigned BitCntW = $clog2(itoar_pkg::DecBits);

  logic [itoar_pkg::DecBits-1:0]  sr_q;
  logic [itoar_pkg::BcdWidth-1:0] bcd_q, adj;
  logic [BitCntW-1:0]             cnt_q;
  logic                           run_q, done_q;

  always_comb begin
    for (int i = 0; i < int'(itoar_pkg::DecDigits); i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                 : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (load_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + BitCntW'(1);
        if (cnt_q == BitCntW'(itoar_pkg::DecBits - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sr_q  <= mag_i;
      bcd_q <= '0;
    end else if (run_q) begin
      sr_q  <= {sr_q[itoar_pkg::DecBits-2:0], 1'b0};
      bcd_q <= {adj[itoar_pkg::BcdWidth-2:0], sr_q[itoar_pkg::DecBits-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// File: rtl/core/itoar_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character emitter
// Shifts out one digit per cycle, dropping leading zeros, with sign and index.
// ----------------------------------------------------------------------------
module itoar_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itoar_pkg::emit_cmd_t  cmd_i,
  output logic                  strobe_o,
  output itoar_pkg::result_t    result_o,
  output logic                  done_o
);

  localparam int unsigned DW = itoar_pkg::DigWidth;
  localparam int unsigned CW = itoar_pkg::CntWidth;

  logic [DW-1:0] dig_q;
  logic [CW-1:0] cnt_q;
  logic [3:0]    pos_q;
  logic          neg_q, upper_q, started_q, active_q;
  logic [3:0]    top_nib;
  logic          skip, last;

  assign top_nib = dig_q[DW-1 -: 4];
  assign skip    = !started_q && (top_nib == 4'd0) && (cnt_q > CW'(1));
  assign last    = !neg_q && (cnt_q == CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      neg_q     <= 1'b0;
      started_q <= 1'b0;
      cnt_q     <= '0;
      pos_q     <= '0;
    end else if (cmd_i.load) begin
      active_q  <= 1'b1;
      neg_q     <= cmd_i.neg;
      started_q <= 1'b0;
      cnt_q     <= cmd_i.count;
      pos_q     <= '0;
    end else if (active_q && !skip) begin
      pos_q <= pos_q + 4'd1;
      if (neg_q) begin
        neg_q <= 1'b0;
      end else begin
        started_q <= 1'b1;
        cnt_q     <= cnt_q - CW'(1);
        if (last) begin
          active_q <= 1'b0;
        end
      end
    end else if (active_q) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dig_q   <= cmd_i.digits;
      upper_q <= cmd_i.upper;
    end else if (active_q && !neg_q) begin
      dig_q <= {dig_q[DW-5:0], 4'd0};
    end else if (active_q && skip) begin
      dig_q <= {dig_q[DW-5:0], 4'd0};
    end
  end

  assign strobe_o           = active_q && !skip;
  assign result_o.character = neg_q ? itoar_pkg::CHAR_MINUS
                                    : itoar_pkg::digit_char(top_nib, upper_q);
  assign result_o.position  = pos_q;
  assign result_o.last      = last;
  assign done_o             = strobe_o && last;

endmodule

// File: test/itoar_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII text checker
// Watches the command and character channels of the converter, renders the
// expected text of every accepted command and compares each emitted character.
// ----------------------------------------------------------------------------
module itoar_text_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  itoar_pkg::cmd_t    cmd_i,
  input  logic               strobe_i,
  input  itoar_pkg::result_t result_i,
  output int                 outstanding_o,
  output int                 fails_o
);

  localparam logic [31:0] DecRadix = 32'd10;
  localparam logic [3:0]  HexShift = 4'd4;

  itoar_pkg::result_t expected_chars[$];
  int                 mismatches;

  assign fails_o = mismatches;

  // Renders the text of one command as a sequence of characters.
  function automatic int render_text(input itoar_pkg::cmd_t c,
                                     output itoar_pkg::result_t chars [itoar_pkg::HexDigits]);
    logic [31:0] mag;
    logic [63:0] hv;
    logic [3:0]  nib;
    logic [7:0]  rev [itoar_pkg::HexDigits];
    logic [7:0]  txt [itoar_pkg::HexDigits];
    int          nrev;
    int          n;
    nrev = 0;
    n    = 0;
    for (int k = 0; k < int'(itoar_pkg::HexDigits); k++) begin
      chars[k] = '0;
      rev[k]   = '0;
      txt[k]   = '0;
    end
    if (c.halted) begin
      return 0;
    end
    if (c.op == itoar_pkg::OP_SDEC || c.op == itoar_pkg::OP_UDEC) begin
      mag = c.value[31:0];
      if (c.op == itoar_pkg::OP_SDEC && mag[31]) begin
        // Two's complement negation also covers the most negative value.
        mag    = 32'd0 - mag;
        txt[n] = itoar_pkg::CHAR_MINUS;
        n++;
      end
      do begin
        rev[nrev] = itoar_pkg::CHAR_ZERO + 8'(mag % DecRadix);
        nrev++;
        mag = mag / DecRadix;
      end while (mag != 32'd0 && nrev < int'(itoar_pkg::DecDigits));
    end else begin
      hv = c.value;
      do begin
        nib = hv[3:0];
        if (nib < 4'(DecRadix)) begin
          rev[nrev] = itoar_pkg::CHAR_ZERO + {4'd0, nib};
        end else begin
          rev[nrev] = ((c.op == itoar_pkg::OP_HEXU) ? itoar_pkg::CHAR_UPA
                                                    : itoar_pkg::CHAR_LOWA)
                      + {4'd0, nib} - 8'(DecRadix);
        end
        nrev++;
        hv = hv >> HexShift;
      end while (hv != 64'd0 && nrev < int'(itoar_pkg::HexDigits));
    end
    while (nrev > 0 && n < int'(itoar_pkg::HexDigits)) begin
      nrev--;
      txt[n] = rev[nrev];
      n++;
    end
    for (int k = 0; k < n; k++) begin
      chars[k].character = txt[k];
      chars[k].position  = 4'(k);
      chars[k].last      = (k == n - 1);
    end
    return n;
  endfunction

  always @(posedge clk_i) begin
    itoar_pkg::result_t rendered [itoar_pkg::HexDigits];
    itoar_pkg::result_t want;
    int                 count;
    if (!rst_ni) begin
      expected_chars.delete();
      mismatches    = 0;
      outstanding_o <= 0;
    end else begin
      // A character can never belong to a command accepted at the same edge,
      // so new expectations are queued before the character is checked.
      if (start_i && !busy_i) begin
        count = render_text(cmd_i, rendered);
        for (int k = 0; k < count; k++) begin
          expected_chars.push_back(rendered[k]);
        end
      end
      if (strobe_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character 0x%02h at position %0d",
                 result_i.character, result_i.position);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (result_i.character !== want.character) begin
            $error("character: expected 0x%02h, got 0x%02h", want.character,
                   result_i.character);
            mismatches++;
          end
          if (result_i.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, result_i.position);
            mismatches++;
          end
          if (result_i.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, result_i.last);
            mismatches++;
          end
        end
      end
      outstanding_o <= expected_chars.size();
    end
  end

endmodule

// File: test/integer_to_ascii_radix_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter testbench
// Drives directed and random print commands with random idle gaps into the
// converter and lets a side checker compare every emitted character.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_core_tb;

  // Number of random commands after the directed ones.
  localparam int RandomCmds = 280;
  // Cycles without an accepted command or an emitted character before the run
  // is declared hung. The limit lies well above the slowest command plus the
  // longest sender gap, so this leaves a wide margin.
  localparam int HangLimit  = 4000;
  // Quiet time after the last expected character, to catch stray output.
  localparam int DrainCycles = 120;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  itoar_pkg::cmd_t    cmd;
  logic               strobe_o;
  itoar_pkg::result_t result;
  int                 outstanding;
  int                 chk_fails;
  int                 idle_cycles;
  bit                 burst;

  integer_to_ascii_radix_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd),
    .strobe_o(strobe_o),
    .result_o(result)
  );

  itoar_text_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .strobe_i     (strobe_o),
    .result_i     (result),
    .outstanding_o(outstanding),
    .fails_o      (chk_fails)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: any accepted transaction on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HangLimit) begin
      $display("** integer_to_ascii_radix_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one command and holds it until the converter takes it. Start is
  // left high afterwards so that back-to-back commands never pulse it low.
  task automatic send_cmd(input logic [1:0] op, input logic [63:0] value, input logic halted);
    itoar_pkg::cmd_t c;
    c.op     = op;
    c.value  = value;
    c.halted = halted;
    start <= 1'b1;
    cmd   <= c;
    do begin
      @(posedge clk_i);
    end while (busy);
  endtask

  // Drops start for a number of cycles; the command bus carries noise meanwhile,
  // which the converter must ignore.
  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      cmd   <= '{op: 2'($urandom), value: {$urandom, $urandom}, halted: 1'($urandom)};
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(30, 150);
  endfunction

  // Stops sending until every character already owed has been emitted. The
  // first edge lets the checker count a command accepted at the current edge.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Values that stress decimal digit boundaries and the sign bit, with random
  // upper bits that the decimal modes must ignore.
  function automatic logic [63:0] pick_value();
    logic [31:0] edges [12];
    logic [63:0] v;
    edges = '{32'd0, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999, 32'd1000000000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFF6};
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return v;
      1: return v >> $urandom_range(0, 63);
      2: return {v[63:32], edges[$urandom_range(0, 11)]};
      3: return 64'($urandom_range(0, 20));
      4: return {v[63:32], 32'hFFFF_FFFF - 32'($urandom_range(0, 200))};
      default: return {$urandom, 32'($signed(v[15:0]))};
    endcase
  endfunction

  initial begin
    logic [1:0]  op;
    logic [63:0] value;
    logic        halted;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd         = '0;
    burst       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero and extremes of each mode, the most negative signed
    // value, upper bits that decimal modes drop, and halted commands.
    send_cmd(itoar_pkg::OP_SDEC, 64'd0, 1'b0);
    send_cmd(itoar_pkg::OP_SDEC, 64'd1, 1'b0);
    send_cmd(itoar_pkg::OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_cmd(itoar_pkg::OP_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b0);
    pause(2);
    send_cmd(itoar_pkg::OP_SDEC, 64'h0000_0000_8000_0000, 1'b0);
    send_cmd(itoar_pkg::OP_SDEC, 64'hDEAD_BEEF_8000_0000, 1'b0);
    send_cmd(itoar_pkg::OP_UDEC, 64'd0, 1'b0);
    send_cmd(itoar_pkg::OP_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b0);
    send_cmd(itoar_pkg::OP_UDEC, 64'hFFFF_FFFF_3B9A_CA00, 1'b0);
    send_cmd(itoar_pkg::OP_UDEC, 64'h1234_5678_0000_0009, 1'b0);
    pause(7);
    send_cmd(itoar_pkg::OP_UDEC, 64'h8000_0000_0000_000A, 1'b0);
    send_cmd(itoar_pkg::OP_HEXL, 64'd0, 1'b0);
    send_cmd(itoar_pkg::OP_HEXL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_cmd(itoar_pkg::OP_HEXL, 64'hABCD_EF01_2345_6789, 1'b0);
    send_cmd(itoar_pkg::OP_HEXL, 64'h0000_0000_0000_00A0, 1'b0);
    send_cmd(itoar_pkg::OP_HEXU, 64'hFEDC_BA98_7654_3210, 1'b0);
    send_cmd(itoar_pkg::OP_HEXU, 64'h8000_0000_0000_0000, 1'b0);
    send_cmd(itoar_pkg::OP_HEXU, 64'h0000_0000_0000_000F, 1'b0);
    send_cmd(itoar_pkg::OP_SDEC, 64'hFFFF_FFFF_8000_0000, 1'b1);
    send_cmd(itoar_pkg::OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_cmd(itoar_pkg::OP_HEXL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_cmd(itoar_pkg::OP_HEXU, 64'd0, 1'b1);
    wait_drained();

    // Random part. Bursts with no gaps alternate with stretches of random gaps,
    // and once halfway the sender waits until the converter has gone quiet.
    for (int i = 0; i < RandomCmds; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        burst = ~burst;
      end
      if (i == RandomCmds / 2) begin
        wait_drained();
      end
      op     = 2'($urandom_range(0, 3));
      value  = pick_value();
      halted = ($urandom_range(0, 9) == 0);
      send_cmd(op, value, halted);
      pause(pick_gap());
    end

    // End of stimulus: wait for every owed character, then a quiet stretch in
    // which any extra character would be flagged by the checker.
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (chk_fails == 0 && outstanding == 0) begin
      $display("** integer_to_ascii_radix_core: PASSED **");
    end else begin
      if (outstanding != 0) begin
        $error("%0d expected characters never arrived", outstanding);
      end
      $display("** integer_to_ascii_radix_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/itoar_pkg.sv
rtl/core/itoar_dabble.sv
rtl/core/itoar_emit.sv
rtl/core/integer_to_ascii_radix_core.sv
test/itoar_text_checker.sv
test/integer_to_ascii_radix_core_tb.sv
